### design/scatter_nd_reduce_engine_unit_assert.svh
// assertion macros for the scatter-nd reduce engine
// no dependencies; included by modules that check their own logic
`ifndef SCATTER_ND_REDUCE_ENGINE_UNIT_ASSERT_SVH
`define SCATTER_ND_REDUCE_ENGINE_UNIT_ASSERT_SVH

`define SNDR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SNDR_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/sndr_pkg.sv
// shared types, codes and helpers of the scatter-nd reduce engine
// no dependencies
package sndr_pkg;

   localparam int MEM_DEPTH = 4096;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int MAX_RANK  = 4;
   localparam int STEP_W    = $clog2(MAX_RANK);
   localparam int DIM_W     = 13;
   localparam int WORD_W    = 64;
   localparam int CSR_W     = 13;

   localparam logic [2:0] RED_NONE = 3'd0;
   localparam logic [2:0] RED_ADD  = 3'd1;
   localparam logic [2:0] RED_MUL  = 3'd2;
   localparam logic [2:0] RED_MAX  = 3'd3;
   localparam logic [2:0] RED_MIN  = 3'd4;

   localparam logic [2:0] CSR_RANK   = 3'd0;
   localparam logic [2:0] CSR_DIM0   = 3'd1;
   localparam logic [2:0] CSR_DIM1   = 3'd2;
   localparam logic [2:0] CSR_DIM2   = 3'd3;
   localparam logic [2:0] CSR_DIM3   = 3'd4;
   localparam logic [2:0] CSR_IDXLEN = 3'd5;
   localparam logic [2:0] CSR_MODE   = 3'd6;
   localparam logic [2:0] CSR_ETYPE  = 3'd7;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_SCATTER = 2'd1,
      CMD_READ    = 2'd2,
      CMD_BAD     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ET_INT8  = 2'd0,
      ET_UINT8 = 2'd1,
      ET_INT32 = 2'd2,
      ET_INT64 = 2'd3
   } etype_type;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_SCATTER = 2'd1,
      OP_READ    = 2'd2,
      OP_FLAG    = 2'd3
   } op_kind_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_STEP,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_FETCH,
      B_MUL1,
      B_MUL2
   } back_state_type;

   typedef struct packed {
      logic [2:0]                      rank;
      logic [MAX_RANK-1:0][DIM_W-1:0]  dim_size;
      logic [2:0]                      index_len;
      logic [2:0]                      mode;
      etype_type                       etype;
   } cfg_type;

   typedef struct packed {
      op_kind_type        kind;
      logic [ADDR_W-1:0]  addr;
      logic [WORD_W-1:0]  value;
   } op_type;

   function automatic logic [WORD_W-1:0] norm(input logic [WORD_W-1:0] x,
                                              input etype_type et);
      logic [WORD_W-1:0] r;
      case (et)
         ET_INT8:  r = {{(WORD_W-8){x[7]}}, x[7:0]};
         ET_UINT8: r = {{(WORD_W-8){1'b0}}, x[7:0]};
         ET_INT32: r = {{(WORD_W-32){x[31]}}, x[31:0]};
         default:  r = x;
      endcase
      return r;
   endfunction

endpackage

### design/sndr_req_if.sv
// request channel of the scatter-nd reduce engine
// depends on sndr_pkg
interface sndr_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         cmd;
   logic [sndr_pkg::ADDR_W-1:0]        linear_addr;
   logic signed [sndr_pkg::DIM_W-1:0]  index_0;
   logic signed [sndr_pkg::DIM_W-1:0]  index_1;
   logic signed [sndr_pkg::DIM_W-1:0]  index_2;
   logic signed [sndr_pkg::DIM_W-1:0]  index_3;
   logic [11:0]                        slice_pos;
   logic signed [sndr_pkg::WORD_W-1:0] item_value;

   modport source (output valid, cmd, linear_addr, index_0, index_1, index_2, index_3,
                   slice_pos, item_value, input ready);
   modport sink (input valid, cmd, linear_addr, index_0, index_1, index_2, index_3,
                 slice_pos, item_value, output ready);
endinterface

### design/sndr_rsp_if.sv
// response channel of the scatter-nd reduce engine
// depends on sndr_pkg
interface sndr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [sndr_pkg::WORD_W-1:0] read_value;
   logic                               status;

   modport source (output valid, read_value, status, input ready);
   modport sink (input valid, read_value, status, output ready);
endinterface

### design/sndr_front.sv
// front end: accepts request beats, checks indices and builds the element address
// depends on sndr_pkg and sndr_req_if
module sndr_front (
   input  logic              clock,
   input  logic              reset,
   input  sndr_pkg::cfg_type cfg,
   sndr_req_if.sink          req_chan,
   output logic              push,
   output sndr_pkg::op_type  push_op,
   input  logic              full
);

   sndr_pkg::front_state_type state_ff, state_in;
   logic [sndr_pkg::MAX_RANK-1:0][sndr_pkg::DIM_W-1:0] idx_ff;
   logic [11:0]                     pos_ff;
   logic [sndr_pkg::STEP_W-1:0]     step_ff;
   logic [11:0]                     acc_ff, acc_in;
   logic                            ovf_ff, ovf_in;
   logic                            bad_ff, bad_in;
   logic [sndr_pkg::DIM_W-1:0]      slice_ff, slice_in;
   logic                            big_ff, big_in;
   logic                            zero_ff, zero_in;
   sndr_pkg::op_type                op_ff;

   logic [2:0]                  eff_rank;
   logic                        cfg_ok;
   logic                        accept;
   logic                        in_idx;
   logic                        last;
   logic [sndr_pkg::DIM_W-1:0]  d;
   logic signed [13:0]          v14, vw;
   logic                        comp_bad;
   logic [25:0]                 sum;
   logic [25:0]                 sprod;
   logic [12:0]                 fin_addr;
   logic                        flagged;

   always_comb begin
      if (cfg.rank == 3'd0) begin
         eff_rank = 3'd1;
      end else if (cfg.rank > 3'(sndr_pkg::MAX_RANK)) begin
         eff_rank = 3'(sndr_pkg::MAX_RANK);
      end else begin
         eff_rank = cfg.rank;
      end
      cfg_ok = (cfg.index_len != 3'd0) && (cfg.index_len <= eff_rank) &&
               (cfg.mode <= sndr_pkg::RED_MIN);
   end

   always_comb begin
      d        = cfg.dim_size[step_ff];
      in_idx   = {1'b0, step_ff} < cfg.index_len;
      last     = {1'b0, step_ff} == (eff_rank - 3'd1);
      v14      = {idx_ff[step_ff][sndr_pkg::DIM_W-1], idx_ff[step_ff]};
      vw       = v14[13] ? (v14 + $signed({1'b0, d})) : v14;
      comp_bad = vw[13] || (vw >= $signed({1'b0, d}));
      sum      = ({14'd0, acc_ff} * {13'd0, d}) + (in_idx ? {13'd0, vw[12:0]} : 26'd0);
      sprod    = {13'd0, slice_ff} * {13'd0, d};
      acc_in   = sum[11:0];
      ovf_in   = ovf_ff | (|sum[25:12]);
      bad_in   = bad_ff | (in_idx & comp_bad);
      slice_in = in_idx ? slice_ff : sprod[12:0];
      big_in   = big_ff | (!in_idx & (|sprod[25:12]));
      zero_in  = zero_ff | (!in_idx & (d == '0));
      fin_addr = {1'b0, acc_in} + {1'b0, pos_ff};
      flagged  = bad_in || ovf_in || zero_in || (!big_in && ({1'b0, pos_ff} >= slice_in)) ||
                 fin_addr[12];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sndr_pkg::F_IDLE: begin
            if (accept) begin
               if ((req_chan.cmd == sndr_pkg::CMD_SCATTER) && cfg_ok) begin
                  state_in = sndr_pkg::F_STEP;
               end else begin
                  state_in = sndr_pkg::F_PUSH;
               end
            end
         end
         sndr_pkg::F_STEP: begin
            if (last) begin
               state_in = sndr_pkg::F_PUSH;
            end
         end
         sndr_pkg::F_PUSH: begin
            if (!full) begin
               state_in = sndr_pkg::F_IDLE;
            end
         end
         default: state_in = sndr_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == sndr_pkg::F_IDLE);
      push           = (state_ff == sndr_pkg::F_PUSH);
      push_op        = op_ff;
   end

   assign accept = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sndr_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff        <= {req_chan.index_3, req_chan.index_2, req_chan.index_1,
                           req_chan.index_0};
         pos_ff        <= req_chan.slice_pos;
         step_ff       <= '0;
         acc_ff        <= '0;
         ovf_ff        <= 1'b0;
         bad_ff        <= 1'b0;
         slice_ff      <= sndr_pkg::DIM_W'(1);
         big_ff        <= 1'b0;
         zero_ff       <= 1'b0;
         op_ff.addr    <= req_chan.linear_addr;
         op_ff.value   <= req_chan.item_value;
         case (req_chan.cmd)
            sndr_pkg::CMD_LOAD:    op_ff.kind <= sndr_pkg::OP_LOAD;
            sndr_pkg::CMD_READ:    op_ff.kind <= sndr_pkg::OP_READ;
            sndr_pkg::CMD_SCATTER: op_ff.kind <= cfg_ok ? sndr_pkg::OP_SCATTER
                                                        : sndr_pkg::OP_FLAG;
            default:               op_ff.kind <= sndr_pkg::OP_FLAG;
         endcase
      end else if (state_ff == sndr_pkg::F_STEP) begin
         step_ff  <= step_ff + 1'b1;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         bad_ff   <= bad_in;
         slice_ff <= slice_in;
         big_ff   <= big_in;
         zero_ff  <= zero_in;
         if (last) begin
            op_ff.addr <= fin_addr[11:0];
            op_ff.kind <= flagged ? sndr_pkg::OP_FLAG : sndr_pkg::OP_SCATTER;
         end
      end
   end

endmodule

### design/sndr_queue.sv
// two-entry queue of classified operations between front and back
// depends on sndr_pkg
module sndr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sndr_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output sndr_pkg::op_type head,
   output logic             empty
);

   sndr_pkg::op_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      full     = (count_ff == 2'd2);
      empty    = (count_ff == 2'd0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      head     = entry_ff[rd_ptr_ff];
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### design/sndr_back.sv
// back end: tensor memory, read-modify-write reduction and response register
// depends on sndr_pkg, sndr_rsp_if and the assertion macro header
`include "scatter_nd_reduce_engine_unit_assert.svh"

module sndr_back (
   input  logic              clock,
   input  logic              reset,
   input  sndr_pkg::cfg_type cfg,
   input  sndr_pkg::op_type  head,
   input  logic              empty,
   output logic              pop,
   sndr_rsp_if.source        rsp_chan
);

   logic [sndr_pkg::WORD_W-1:0] mem [sndr_pkg::MEM_DEPTH];

   sndr_pkg::back_state_type    state_ff, state_in;
   sndr_pkg::op_type            op_ff;
   logic [sndr_pkg::WORD_W-1:0] mem_rd_ff;
   logic [sndr_pkg::WORD_W-1:0] cur_ff, upd_ff, prod_ff;
   logic                        rsp_valid_ff;
   logic [sndr_pkg::WORD_W-1:0] rsp_value_ff;
   logic                        rsp_status_ff;

   logic                        out_free;
   logic [sndr_pkg::WORD_W-1:0] cur, upd, res;
   logic [31:0]                 mul_a, mul_b;
   logic [63:0]                 mulp;
   logic                        mem_we;
   logic [sndr_pkg::ADDR_W-1:0] mem_wa;
   logic [sndr_pkg::WORD_W-1:0] mem_wd;
   logic                        rsp_set;
   logic [sndr_pkg::WORD_W-1:0] rsp_val;
   logic                        rsp_st;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      pop      = (state_ff == sndr_pkg::B_IDLE) && !empty && out_free;
      cur      = sndr_pkg::norm(mem_rd_ff, cfg.etype);
      upd      = sndr_pkg::norm(op_ff.value, cfg.etype);
      case (cfg.mode)
         sndr_pkg::RED_ADD: res = sndr_pkg::norm(cur + upd, cfg.etype);
         sndr_pkg::RED_MAX: res = ($signed(cur) > $signed(upd)) ? cur : upd;
         sndr_pkg::RED_MIN: res = ($signed(cur) > $signed(upd)) ? upd : cur;
         default:           res = upd;
      endcase
      case (state_ff)
         sndr_pkg::B_MUL1: begin
            mul_a = cur_ff[63:32];
            mul_b = upd_ff[31:0];
         end
         sndr_pkg::B_MUL2: begin
            mul_a = cur_ff[31:0];
            mul_b = upd_ff[63:32];
         end
         default: begin
            mul_a = cur[31:0];
            mul_b = upd[31:0];
         end
      endcase
      mulp = mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sndr_pkg::B_IDLE: begin
            if (pop && ((head.kind == sndr_pkg::OP_READ) ||
                        (head.kind == sndr_pkg::OP_SCATTER))) begin
               state_in = sndr_pkg::B_FETCH;
            end
         end
         sndr_pkg::B_FETCH: begin
            if ((op_ff.kind == sndr_pkg::OP_SCATTER) && (cfg.mode == sndr_pkg::RED_MUL)) begin
               state_in = sndr_pkg::B_MUL1;
            end else begin
               state_in = sndr_pkg::B_IDLE;
            end
         end
         sndr_pkg::B_MUL1: state_in = sndr_pkg::B_MUL2;
         sndr_pkg::B_MUL2: state_in = sndr_pkg::B_IDLE;
         default:          state_in = sndr_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      mem_we  = 1'b0;
      mem_wa  = op_ff.addr;
      mem_wd  = res;
      rsp_set = 1'b0;
      rsp_val = '0;
      rsp_st  = 1'b0;
      case (state_ff)
         sndr_pkg::B_IDLE: begin
            if (pop && (head.kind == sndr_pkg::OP_LOAD)) begin
               mem_we  = 1'b1;
               mem_wa  = head.addr;
               mem_wd  = head.value;
               rsp_set = 1'b1;
            end else if (pop && (head.kind == sndr_pkg::OP_FLAG)) begin
               rsp_set = 1'b1;
               rsp_st  = 1'b1;
            end
         end
         sndr_pkg::B_FETCH: begin
            if (op_ff.kind == sndr_pkg::OP_READ) begin
               rsp_set = 1'b1;
               rsp_val = cur;
            end else if (cfg.mode != sndr_pkg::RED_MUL) begin
               mem_we  = 1'b1;
               rsp_set = 1'b1;
            end
         end
         sndr_pkg::B_MUL2: begin
            mem_we  = 1'b1;
            mem_wd  = sndr_pkg::norm(prod_ff + {mulp[31:0], 32'd0}, cfg.etype);
            rsp_set = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sndr_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff     <= head;
         mem_rd_ff <= mem[head.addr];
      end
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rsp_set) begin
         rsp_value_ff  <= rsp_val;
         rsp_status_ff <= rsp_st;
      end
      case (state_ff)
         sndr_pkg::B_FETCH: begin
            cur_ff  <= cur;
            upd_ff  <= upd;
            prod_ff <= mulp;
         end
         sndr_pkg::B_MUL1: begin
            prod_ff <= prod_ff + {mulp[31:0], 32'd0};
         end
         default: begin
            prod_ff <= prod_ff;
         end
      endcase
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;

   `SNDR_ASSERT(a_pop_needs_slot, clock, reset, pop |-> (!rsp_valid_ff || rsp_chan.ready),
                "operation taken while response slot busy")
   `SNDR_ASSERT(a_mul_seq, clock, reset, (state_ff == sndr_pkg::B_MUL1) |=>
                (state_ff == sndr_pkg::B_MUL2), "multiply sequence broken")
   `SNDR_NEVER(a_no_write_mid_mul, clock, reset, mem_we && (state_ff == sndr_pkg::B_MUL1),
               "memory written before product complete")
   `SNDR_ASSERT(a_resp_per_fetch, clock, reset, (state_ff == sndr_pkg::B_FETCH) |->
                ($past(pop) && !rsp_valid_ff), "fetch without pop or with pending response")

endmodule

### design/scatter_nd_reduce_engine_unit.sv
// Scatter-ND reduce engine over a 4096-word tensor memory. Load, read and flagged beats
// go from the front's idle state to push; a scatter beat walks each tensor dimension
// (1 to 4) through the front's address multiplier. The back reads, modifies and writes
// in fetch, or in fetch, mul1 and mul2 for a multiply reduction, which runs a 64-bit
// product as three 32x32 partial products on one multiplier. A two-entry queue lets the
// front work on the next beat while the back finishes. The memory is not cleared.
// depends on sndr_pkg, sndr_req_if, sndr_rsp_if, sndr_front, sndr_queue, sndr_back
module scatter_nd_reduce_engine_unit (
   input  logic                         clock,
   input  logic                         reset,
   sndr_req_if.sink                     req_chan,
   sndr_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [2:0]                   csr_index,
   input  logic [sndr_pkg::CSR_W-1:0]   csr_wr_data
);

   sndr_pkg::cfg_type cfg_ff;
   logic              push, full, pop, empty;
   sndr_pkg::op_type  push_op, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rank      <= 3'd1;
         cfg_ff.dim_size  <= {sndr_pkg::MAX_RANK{sndr_pkg::DIM_W'(1)}};
         cfg_ff.index_len <= 3'd1;
         cfg_ff.mode      <= sndr_pkg::RED_NONE;
         cfg_ff.etype     <= sndr_pkg::ET_INT32;
      end else if (csr_wr_en) begin
         case (csr_index)
            sndr_pkg::CSR_RANK:   cfg_ff.rank        <= csr_wr_data[2:0];
            sndr_pkg::CSR_DIM0:   cfg_ff.dim_size[0] <= csr_wr_data;
            sndr_pkg::CSR_DIM1:   cfg_ff.dim_size[1] <= csr_wr_data;
            sndr_pkg::CSR_DIM2:   cfg_ff.dim_size[2] <= csr_wr_data;
            sndr_pkg::CSR_DIM3:   cfg_ff.dim_size[3] <= csr_wr_data;
            sndr_pkg::CSR_IDXLEN: cfg_ff.index_len   <= csr_wr_data[2:0];
            sndr_pkg::CSR_MODE:   cfg_ff.mode        <= csr_wr_data[2:0];
            default:              cfg_ff.etype       <= sndr_pkg::etype_type'(csr_wr_data[1:0]);
         endcase
      end
   end

   sndr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .push     (push),
      .push_op  (push_op),
      .full     (full)
   );

   sndr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (full),
      .pop     (pop),
      .head    (head),
      .empty   (empty)
   );

   sndr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
